### rtl/core/sorted_list_merge_defines.svh
// Assertion macros for the sorted list merge block.
// Included by the RTL files that carry concurrent checks; depends on nothing.
`ifndef SORTED_LIST_MERGE_DEFINES_SVH
`define SORTED_LIST_MERGE_DEFINES_SVH

// Same-cycle implication, sampled on clock, masked during reset
`define SLM_CHECK_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, masked during reset
`define SLM_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/slm_pkg.sv
// Shared types and codes for the sorted list merge block.
// Stand-alone package; used by sorted_list_merge.
`timescale 1ns / 1ps

package slm_pkg;

   // Request action codes
   localparam logic [1:0] ACT_PUSH_A = 2'd0;
   localparam logic [1:0] ACT_PUSH_B = 2'd1;
   localparam logic [1:0] ACT_MERGE  = 2'd2;

   localparam int unsigned ELEM_W = 32;

   // Merge sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_PICK = 3'b100
   } state_type;

endpackage

### rtl/core/sorted_list_merge.sv
// Two-way merge of two ascending lists of signed values.
// Push: a push can be taken every cycle while the block is idle.
// Merge of N held entries: each result takes a registered list read (ST_READ),
// then the shared compare (ST_PICK), which waits while the output register is stalled;
// the block takes no item until the last result is registered. An empty merge gives no result and stays idle.
// Synchronous reset clears counts, overflow flag, sequencer and output valid.
// Depends on slm_pkg and sorted_list_merge_defines.svh.
`timescale 1ns / 1ps
`include "sorted_list_merge_defines.svh"

module sorted_list_merge #(
   parameter int unsigned LIST_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_elem_value,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_merged_value,
   output logic               rsp_last_of_run,
   output logic               rsp_overflowed
);

   localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);
   localparam int unsigned IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int unsigned REM_W = $clog2(2 * LIST_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LIST_DEPTH);
   localparam logic [REM_W-1:0] REM_ONE   = REM_W'(1);

   // list stores
   logic signed [slm_pkg::ELEM_W-1:0] mem_a [LIST_DEPTH];
   logic signed [slm_pkg::ELEM_W-1:0] mem_b [LIST_DEPTH];
   logic signed [slm_pkg::ELEM_W-1:0] rd_a_ff;
   logic signed [slm_pkg::ELEM_W-1:0] rd_b_ff;

   slm_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic [CNT_W-1:0] ia_ff, ia_in;
   logic [CNT_W-1:0] ib_ff, ib_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic             overflow_ff, overflow_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [slm_pkg::ELEM_W-1:0] rsp_value_ff, rsp_value_in;
   logic                              rsp_last_ff, rsp_last_in;
   logic                              rsp_ovf_ff, rsp_ovf_in;

   logic             req_take;
   logic             out_free;
   logic             a_avail, b_avail, a_lt_b, take_a;
   logic             push_a, push_b;
   logic [REM_W-1:0] total;

   assign req_stall = (state_ff != slm_pkg::ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign push_a = req_take && (req_action == slm_pkg::ACT_PUSH_A) && (count_a_ff < DEPTH_CNT);
   assign push_b = req_take && (req_action == slm_pkg::ACT_PUSH_B) && (count_b_ff < DEPTH_CNT);
   assign total  = REM_W'(count_a_ff) + REM_W'(count_b_ff);

   // shared compare unit: pick the list head that goes out next
   assign a_avail = ia_ff < count_a_ff;
   assign b_avail = ib_ff < count_b_ff;
   assign a_lt_b  = rd_a_ff < rd_b_ff;
   assign take_a  = a_avail && (!b_avail || a_lt_b);

   // write pushes, read the current heads
   always_ff @(posedge clock) begin
      if (push_a) begin
         mem_a[count_a_ff[IDX_W-1:0]] <= req_elem_value;
      end
      if (push_b) begin
         mem_b[count_b_ff[IDX_W-1:0]] <= req_elem_value;
      end
      rd_a_ff <= mem_a[ia_ff[IDX_W-1:0]];
      rd_b_ff <= mem_b[ib_ff[IDX_W-1:0]];
   end

   // sequencer and list bookkeeping
   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      ia_in        = ia_ff;
      ib_in        = ib_ff;
      rem_in       = rem_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      case (state_ff)
         slm_pkg::ST_IDLE: begin
            if (req_take) begin
               case (req_action)
                  slm_pkg::ACT_PUSH_A: begin
                     if (push_a) begin
                        count_a_in = count_a_ff + CNT_W'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  slm_pkg::ACT_PUSH_B: begin
                     if (push_b) begin
                        count_b_in = count_b_ff + CNT_W'(1);
                     end else begin
                        overflow_in = 1'b1;
                     end
                  end
                  slm_pkg::ACT_MERGE: begin
                     ia_in  = '0;
                     ib_in  = '0;
                     rem_in = total;
                     if (total == '0) begin
                        overflow_in = 1'b0;
                     end else begin
                        state_in = slm_pkg::ST_READ;
                     end
                  end
                  default: begin
                     // unused code: drop
                  end
               endcase
            end
         end
         slm_pkg::ST_READ: begin
            state_in = slm_pkg::ST_PICK;
         end
         slm_pkg::ST_PICK: begin
            // hold until the output register can take the item
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = take_a ? rd_a_ff : rd_b_ff;
               rsp_last_in  = (rem_ff == REM_ONE);
               rsp_ovf_in   = overflow_ff;
               ia_in        = ia_ff + CNT_W'(take_a);
               ib_in        = ib_ff + CNT_W'(!take_a);
               rem_in       = rem_ff - REM_ONE;
               if (rem_ff == REM_ONE) begin
                  state_in    = slm_pkg::ST_IDLE;
                  count_a_in  = '0;
                  count_b_in  = '0;
                  overflow_in = 1'b0;
               end else begin
                  state_in = slm_pkg::ST_READ;
               end
            end
         end
         default: begin
            state_in = slm_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slm_pkg::ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // indices and output payload
   always_ff @(posedge clock) begin
      ia_ff        <= ia_in;
      ib_ff        <= ib_in;
      rem_ff       <= rem_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_merged_value = rsp_value_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_overflowed   = rsp_ovf_ff;

   // checks
   `SLM_CHECK_NOW(a_cnt_bound, 1'b1, (count_a_ff <= DEPTH_CNT) && (count_b_ff <= DEPTH_CNT), "list count beyond depth")
   `SLM_CHECK_NOW(a_pick_rem, state_ff == slm_pkg::ST_PICK, (rem_ff != '0) && (a_avail || b_avail), "pick with nothing left")
   `SLM_CHECK_NEXT(a_last_done, (state_ff == slm_pkg::ST_PICK) && out_free && (rem_ff == REM_ONE), (state_ff == slm_pkg::ST_IDLE) && (count_a_ff == '0) && (count_b_ff == '0) && rsp_valid_ff && rsp_last_ff, "merge did not close")
   `SLM_CHECK_NEXT(a_empty_merge, req_take && (req_action == slm_pkg::ACT_MERGE) && (total == '0), (state_ff == slm_pkg::ST_IDLE) && !overflow_ff, "empty merge left state")

endmodule
